[rtl/core/l2fv_pkg.sv]
// shared constants and types for the learning l2 forwarding block
package l2fv_pkg;

   // sizes
   localparam int NUM_PORTS     = 8;
   localparam int TABLE_ENTRIES = 64;
   localparam int REG_COUNT     = 8;

   // field widths
   localparam int PORT_W    = 3;
   localparam int MAC_W     = 48;
   localparam int VLAN_W    = 12;
   localparam int MASK_W    = 8;
   localparam int CSR_IDX_W = 4;

   // register map: vlan of port p sits at CSR_VLAN_PORT0 + p
   localparam logic [CSR_IDX_W-1:0] CSR_VLAN_PORT0 = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VLAN_PORT7 = 4'd7;

   // lookup keys of the transaction in flight
   typedef struct packed {
      logic [PORT_W-1:0] port;
      logic [MAC_W-1:0]  src_mac;
      logic [MAC_W-1:0]  dst_mac;
   } key_type;

   // token handed from cell to cell
   typedef struct packed {
      logic              valid;
      logic              src_done;
      logic              dst_hit;
      logic [PORT_W-1:0] dst_port;
   } tok_type;

endpackage

[rtl/core/l2_learning_forward_vlan.sv]
// learning l2 forwarding with port vlans: mac table chain and egress decision
//
//  channel  ports                                   handshake
//  req      start/busy, req_ingress_port, req_*mac  start & !busy
//  rsp      rsp_valid, rsp_egress_mask, flags       one-cycle strobe
//  csr      csr_valid/csr_ready, index, wdata       valid & ready
//
// a transaction walks the chain of TABLE_ENTRIES cells one cell per cycle,
// so the strobe follows accept through launch_ff, every cell register and rsp_valid_ff;
// an ingress port past NUM_PORTS answers through null_ff with nothing learned.
// busy drops with the strobe, so the next transaction may start right then.
// reset empties the table at once; the receiver cannot stall the strobe.
module l2_learning_forward_vlan
   import l2fv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [PORT_W-1:0]    req_ingress_port,
   input  logic [MAC_W-1:0]     req_source_mac,
   input  logic [MAC_W-1:0]     req_dest_mac,
   output logic                 rsp_valid,
   output logic [MASK_W-1:0]    rsp_egress_mask,
   output logic                 rsp_flooded,
   output logic                 rsp_learn_dropped,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VLAN_W-1:0]    csr_wdata
);

   logic              busy_ff, busy_in;
   logic              launch_ff, launch_in;
   logic              null_ff, null_in;
   key_type           key_ff, key_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [MASK_W-1:0] mask_ff, mask_in;
   logic              flooded_ff, flooded_in;
   logic              dropped_ff, dropped_in;

   logic              accept;
   logic              port_ok;
   logic [VLAN_W-1:0] vlan [REG_COUNT];
   logic [VLAN_W-1:0] in_vlan;
   tok_type           tok_chain [TABLE_ENTRIES+1];
   tok_type           tok_last;

   // vlan registers
   l2fv_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .vlan      (vlan)
   );

   // request capture
   assign accept  = start & ~busy_ff;
   assign port_ok = int'(req_ingress_port) < NUM_PORTS;

   always_comb begin
      key_in    = key_ff;
      launch_in = accept & port_ok;
      null_in   = accept & ~port_ok;
      if (accept) begin
         key_in.port    = req_ingress_port;
         key_in.src_mac = req_source_mac;
         key_in.dst_mac = req_dest_mac;
      end
   end

   // token entering the first cell
   always_comb begin
      tok_chain[0].valid    = launch_ff;
      tok_chain[0].src_done = 1'b0;
      tok_chain[0].dst_hit  = 1'b0;
      tok_chain[0].dst_port = '0;
   end

   // mac table as a chain of entry cells
   for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
      l2fv_cell u_cell (
         .clock (clock),
         .reset (reset),
         .key   (key_ff),
         .tok_i (tok_chain[g]),
         .tok_o (tok_chain[g+1])
      );
   end

   assign tok_last = tok_chain[TABLE_ENTRIES];
   assign in_vlan  = vlan[key_ff.port];

   // egress decision once the token leaves the last cell
   always_comb begin
      mask_in    = '0;
      flooded_in = 1'b0;
      dropped_in = 1'b0;
      if (tok_last.valid) begin
         dropped_in = ~tok_last.src_done;
         if (!tok_last.dst_hit) begin
            flooded_in = 1'b1;
            for (int p = 0; p < NUM_PORTS; p++) begin
               if ((PORT_W'(p) != key_ff.port) && (vlan[p] == in_vlan)) begin
                  mask_in[p] = 1'b1;
               end
            end
         end else if ((tok_last.dst_port != key_ff.port) &&
                      (int'(tok_last.dst_port) < NUM_PORTS) &&
                      (vlan[tok_last.dst_port] == in_vlan)) begin
            mask_in[tok_last.dst_port] = 1'b1;
         end
      end
   end

   // busy from accept until the strobe
   always_comb begin
      rsp_valid_in = tok_last.valid | null_ff;
      busy_in      = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (rsp_valid_in) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         launch_ff    <= 1'b0;
         null_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         launch_ff    <= launch_in;
         null_ff      <= null_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff     <= key_in;
      mask_ff    <= mask_in;
      flooded_ff <= flooded_in;
      dropped_ff <= dropped_in;
   end

   assign busy              = busy_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_egress_mask   = mask_ff;
   assign rsp_flooded       = flooded_ff;
   assign rsp_learn_dropped = dropped_ff;

endmodule

[rtl/core/l2fv_cell.sv]
// one mac table entry with its search and learn logic
module l2fv_cell
   import l2fv_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  key_type key,
   input  tok_type tok_i,
   output tok_type tok_o
);

   logic              valid_ff;
   logic              valid_in;
   logic [MAC_W-1:0]  mac_ff;
   logic [MAC_W-1:0]  mac_in;
   logic [PORT_W-1:0] port_ff;
   logic [PORT_W-1:0] port_in;
   tok_type           tok_ff;
   tok_type           tok_in;

   logic              src_hit;
   logic              place;
   logic              eff_valid;
   logic [MAC_W-1:0]  eff_mac;
   logic [PORT_W-1:0] eff_port;
   logic              dst_match;

   // source match, or first empty entry while the source is still unplaced
   assign src_hit = tok_i.valid & valid_ff & (mac_ff == key.src_mac);
   assign place   = tok_i.valid & ~valid_ff & ~tok_i.src_done;

   // entry as it reads after this transaction's learn step
   assign eff_valid = valid_ff | place;
   assign eff_mac   = place ? key.src_mac : mac_ff;
   assign eff_port  = (src_hit | place) ? key.port : port_ff;
   assign dst_match = tok_i.valid & eff_valid & (eff_mac == key.dst_mac);

   // entry update
   always_comb begin
      valid_in = eff_valid;
      mac_in   = eff_mac;
      port_in  = eff_port;
   end

   // token passed on to the next cell
   always_comb begin
      tok_in.valid    = tok_i.valid;
      tok_in.src_done = tok_i.src_done | src_hit | place;
      tok_in.dst_hit  = tok_i.dst_hit | dst_match;
      tok_in.dst_port = dst_match ? eff_port : tok_i.dst_port;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // entry payload, written only when a transaction passes
   always_ff @(posedge clock) begin
      if (tok_i.valid) begin
         mac_ff  <= mac_in;
         port_ff <= port_in;
      end
   end

   // token register, only the valid bit is reset
   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.src_done <= tok_in.src_done;
      tok_ff.dst_hit  <= tok_in.dst_hit;
      tok_ff.dst_port <= tok_in.dst_port;
   end

   assign tok_o = tok_ff;

endmodule

[rtl/core/l2fv_csr.sv]
// per-port vlan registers behind the csr write channel
module l2fv_csr
   import l2fv_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VLAN_W-1:0]    csr_wdata,
   output logic [VLAN_W-1:0]    vlan [REG_COUNT]
);

   logic [VLAN_W-1:0] vlan_ff [REG_COUNT];
   logic [VLAN_W-1:0] vlan_in [REG_COUNT];
   logic              in_map;

   assign csr_ready = 1'b1;

   // indexes past the map are accepted and dropped
   assign in_map = (csr_index >= CSR_VLAN_PORT0) && (csr_index <= CSR_VLAN_PORT7);

   always_comb begin
      vlan_in = vlan_ff;
      if (csr_valid && in_map) begin
         vlan_in[csr_index[PORT_W-1:0] - CSR_VLAN_PORT0[PORT_W-1:0]] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < REG_COUNT; i++) begin
            vlan_ff[i] <= '0;
         end
      end else begin
         vlan_ff <= vlan_in;
      end
   end

   assign vlan = vlan_ff;

endmodule

[dv/tb_l2_learning_forward_vlan.sv]
// self-checking testbench for the learning l2 forwarding block with port vlans
module tb_l2_learning_forward_vlan;
   timeunit 1ns;
   timeprecision 1ps;

   import l2fv_pkg::*;

   localparam int CLOCK_HALF     = 6;
   localparam int RESET_CYCLES   = 7;
   localparam int PHASE_FRAMES   = 200;
   localparam int POOL_DEPTH     = 256;
   localparam int MAX_FRAME_GAP  = 80;
   localparam int DRAIN_CYCLES   = 80;
   localparam int RUN_LIMIT_NS   = 12_000_000;

   localparam bit [MAC_W-1:0] MAC_ZERO = '0;
   localparam bit [MAC_W-1:0] MAC_ONES = '1;
   localparam bit [MAC_W-1:0] MAC_ALT5 = 48'h5555_5555_5555;
   localparam bit [MAC_W-1:0] MAC_ALTA = 48'hAAAA_AAAA_AAAA;
   localparam bit [MAC_W-1:0] STA_A    = 48'h0200_0000_00A1;
   localparam bit [MAC_W-1:0] STA_B    = 48'h0200_0000_00B2;
   localparam bit [MAC_W-1:0] STA_C    = 48'h0200_0000_00C3;
   localparam bit [MAC_W-1:0] STA_D    = 48'h0200_0000_00D4;
   localparam bit [MAC_W-1:0] STA_E    = 48'h0200_0000_00E5;
   localparam bit [MAC_W-1:0] STA_F    = 48'h0200_0000_00F6;
   localparam bit [MAC_W-1:0] STA_G    = 48'h0200_0000_0107;
   localparam bit [MAC_W-1:0] STA_H    = 48'h0200_0000_0118;
   localparam bit [MAC_W-1:0] STA_I    = 48'h0200_0000_0129;
   localparam bit [MAC_W-1:0] STA_J    = 48'h0200_0000_013A;
   localparam bit [MAC_W-1:0] STA_NONE = 48'h0123_4567_89AB;

   // vlan layouts used by the random phases
   typedef enum int {
      PLAN_ALL_MAX,
      PLAN_DISTINCT,
      PLAN_EVEN_ODD,
      PLAN_EXTREMES,
      PLAN_RANDOM,
      PLAN_ALL_ZERO,
      PLAN_COUNT
   } vlan_plan_type;

   typedef struct packed {
      logic [MASK_W-1:0] egress_mask;
      logic              flooded;
      logic              learn_dropped;
   } fwd_decision_type;

   typedef struct {
      bit [PORT_W-1:0]  port;
      bit [MAC_W-1:0]   src;
      bit [MAC_W-1:0]   dst;
      bit               by_hand;
      fwd_decision_type given;
   } frame_row_type;

   // dut ports
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [PORT_W-1:0]    req_ingress_port = '0;
   logic [MAC_W-1:0]     req_source_mac = '0;
   logic [MAC_W-1:0]     req_dest_mac = '0;
   logic                 rsp_valid;
   logic [MASK_W-1:0]    rsp_egress_mask;
   logic                 rsp_flooded;
   logic                 rsp_learn_dropped;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [VLAN_W-1:0]    csr_wdata = '0;

   // predictor copy of the vlan registers and the mac table
   bit [VLAN_W-1:0] port_vlan [REG_COUNT];
   bit              fdb_valid [TABLE_ENTRIES];
   bit [MAC_W-1:0]  fdb_mac   [TABLE_ENTRIES];
   bit [PORT_W-1:0] fdb_port  [TABLE_ENTRIES];

   fwd_decision_type decisions_due [$];
   bit [MAC_W-1:0]   seen_macs [$];
   bit [VLAN_W-1:0]  next_vlan [REG_COUNT];
   int               error_count = 0;
   bit               steady_stretch = 1'b0;

   // all ports in vlan 0 after reset
   frame_row_type shared_vlan_rows [8] = '{
      '{3'd0, MAC_ZERO, MAC_ONES, 1'b1, '{8'hFE, 1'b1, 1'b0}},
      '{3'd7, MAC_ONES, MAC_ZERO, 1'b1, '{8'h01, 1'b0, 1'b0}},
      '{3'd3, STA_A,    STA_A,    1'b1, '{8'h00, 1'b0, 1'b0}},
      '{3'd2, MAC_ZERO, MAC_ONES, 1'b0, '0},
      '{3'd5, STA_B,    MAC_ZERO, 1'b0, '0},
      '{3'd1, MAC_ALT5, MAC_ALTA, 1'b0, '0},
      '{3'd6, MAC_ALTA, MAC_ALT5, 1'b0, '0},
      '{3'd4, MAC_ONES, STA_B,    1'b0, '0}
   };

   // ports 0/1 share vlan 0, ports 2/3 share 4095, the rest stand alone
   frame_row_type split_vlan_rows [8] = '{
      '{3'd5, STA_C,    STA_D,    1'b1, '{8'h00, 1'b1, 1'b0}},
      '{3'd0, STA_E,    MAC_ALT5, 1'b1, '{8'h02, 1'b0, 1'b0}},
      '{3'd2, STA_F,    STA_A,    1'b1, '{8'h08, 1'b0, 1'b0}},
      '{3'd4, STA_G,    MAC_ZERO, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{3'd2, STA_H,    STA_I,    1'b1, '{8'h08, 1'b1, 1'b0}},
      '{3'd6, STA_I,    MAC_ONES, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{3'd7, STA_J,    STA_NONE, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{3'd1, MAC_ZERO, STA_E,    1'b0, '0}
   };

   l2_learning_forward_vlan DUT (
      .clock,
      .reset,
      .start,
      .busy,
      .req_ingress_port,
      .req_source_mac,
      .req_dest_mac,
      .rsp_valid,
      .rsp_egress_mask,
      .rsp_flooded,
      .rsp_learn_dropped,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // table slot holding mac, or -1
   function automatic int find_station(bit [MAC_W-1:0] mac);
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (fdb_valid[i] && fdb_mac[i] == mac) return i;
      end
      return -1;
   endfunction

   // learn the source, then pick the egress ports for the destination
   function automatic fwd_decision_type decide_forwarding(bit [PORT_W-1:0] port,
                                                          bit [MAC_W-1:0] src,
                                                          bit [MAC_W-1:0] dst);
      fwd_decision_type d;
      int               slot;
      bit [PORT_W-1:0]  out_port;
      d = '0;
      if (int'(port) >= NUM_PORTS) return d;

      // learn: refresh a known source, else take the lowest free slot
      slot = find_station(src);
      if (slot < 0) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!fdb_valid[i]) begin
               slot = i;
               break;
            end
         end
         if (slot < 0) begin
            d.learn_dropped = 1'b1;
         end else begin
            fdb_valid[slot] = 1'b1;
            fdb_mac[slot]   = src;
         end
      end
      if (slot >= 0) fdb_port[slot] = port;

      // forward: flood inside the ingress vlan or send to the known port
      slot = find_station(dst);
      if (slot < 0) begin
         d.flooded = 1'b1;
         for (int p = 0; p < NUM_PORTS && p < REG_COUNT; p++) begin
            if (p != int'(port) && port_vlan[p] == port_vlan[port]) d.egress_mask[p] = 1'b1;
         end
      end else begin
         out_port = fdb_port[slot];
         if (out_port != port && int'(out_port) < NUM_PORTS &&
             port_vlan[out_port] == port_vlan[port]) begin
            d.egress_mask[out_port] = 1'b1;
         end
      end
      return d;
   endfunction

   function automatic bit [MAC_W-1:0] random_mac();
      bit [63:0] w;
      w = {$urandom, $urandom};
      return w[MAC_W-1:0];
   endfunction

   // an address seen recently on the wire
   function automatic bit [MAC_W-1:0] pool_mac();
      if (seen_macs.size() == 0) return random_mac();
      return seen_macs[$urandom_range(0, seen_macs.size() - 1)];
   endfunction

   // an address from a random table slot, or from the pool if that slot is empty
   function automatic bit [MAC_W-1:0] known_station();
      int slot;
      slot = $urandom_range(0, TABLE_ENTRIES - 1);
      return fdb_valid[slot] ? fdb_mac[slot] : pool_mac();
   endfunction

   function automatic bit take_pause();
      return !steady_stretch && ($urandom_range(0, 99) < 36);
   endfunction

   // one frame header transaction; start stays high for a back-to-back follower
   task automatic send_frame(bit [PORT_W-1:0] port, bit [MAC_W-1:0] src,
                             bit [MAC_W-1:0] dst, bit by_hand, fwd_decision_type given);
      fwd_decision_type d;
      if (take_pause()) begin
         start <= 1'b0;
         repeat ($urandom_range(1, MAX_FRAME_GAP)) @(posedge clock);
      end
      start            <= 1'b1;
      req_ingress_port <= port;
      req_source_mac   <= src;
      req_dest_mac     <= dst;
      do @(posedge clock); while (busy !== 1'b0);
      d = decide_forwarding(port, src, dst);
      decisions_due = {decisions_due, (by_hand ? given : d)};
      seen_macs = {seen_macs, src, dst};
      while (seen_macs.size() > POOL_DEPTH) void'(seen_macs.pop_front());
   endtask

   task automatic write_csr(bit [CSR_IDX_W-1:0] idx, bit [VLAN_W-1:0] val);
      if (take_pause()) begin
         csr_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      if (idx <= CSR_VLAN_PORT7) port_vlan[PORT_W'(idx - CSR_VLAN_PORT0)] = val;
   endtask

   // drain the block, then load next_vlan into the port registers
   task automatic program_vlans();
      bit [CSR_IDX_W-1:0] stray;
      start <= 1'b0;
      while (decisions_due.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
      for (int p = 0; p < REG_COUNT; p++) begin
         write_csr(CSR_VLAN_PORT0 + CSR_IDX_W'(p), next_vlan[p]);
      end
      // an index past the register map must change nothing
      if ($urandom_range(0, 1)) begin
         stray = CSR_IDX_W'($urandom_range(int'(CSR_VLAN_PORT7) + 1, 2**CSR_IDX_W - 1));
         write_csr(stray, VLAN_W'($urandom));
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stimulus
   initial begin
      fwd_decision_type  none;
      vlan_plan_type     plan;
      bit [VLAN_W-1:0]   ids [3];
      bit [PORT_W-1:0]   port;
      bit [MAC_W-1:0]    src;
      bit [MAC_W-1:0]    dst;
      int                pick;
      none = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed frames with every port in the reset vlan
      foreach (shared_vlan_rows[i]) begin
         send_frame(shared_vlan_rows[i].port, shared_vlan_rows[i].src, shared_vlan_rows[i].dst,
                    shared_vlan_rows[i].by_hand, shared_vlan_rows[i].given);
      end

      // directed frames across split vlans
      next_vlan = '{12'h000, 12'h000, 12'hFFF, 12'hFFF, 12'h001, 12'h002, 12'h800, 12'h7FF};
      program_vlans();
      foreach (split_vlan_rows[i]) begin
         send_frame(split_vlan_rows[i].port, split_vlan_rows[i].src, split_vlan_rows[i].dst,
                    split_vlan_rows[i].by_hand, split_vlan_rows[i].given);
      end

      // random traffic, one vlan layout per phase
      for (int k = 0; k < int'(PLAN_COUNT); k++) begin
         plan = vlan_plan_type'(k);
         foreach (ids[i]) ids[i] = VLAN_W'($urandom);
         for (int p = 0; p < REG_COUNT; p++) begin
            case (plan)
               PLAN_ALL_MAX:  next_vlan[p] = '1;
               PLAN_DISTINCT: next_vlan[p] = VLAN_W'(p * 585);
               PLAN_EVEN_ODD: next_vlan[p] = (p % 2) ? ids[1] : ids[0];
               PLAN_EXTREMES: next_vlan[p] = $urandom_range(0, 1) ? '1 : '0;
               PLAN_RANDOM:   next_vlan[p] = ids[$urandom_range(0, 2)];
               default:       next_vlan[p] = '0;
            endcase
         end
         program_vlans();
         // one whole phase runs without pauses
         steady_stretch = (plan == PLAN_EVEN_ODD);
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            port = PORT_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 35)      src = random_mac();
            else if (pick < 75) src = pool_mac();
            else if (pick < 88) src = known_station();
            else if (pick < 94) src = $urandom_range(0, 1) ? MAC_ONES : MAC_ZERO;
            else                src = MAC_ONES ^ (MAC_W'(1) << $urandom_range(0, MAC_W - 1));
            pick = $urandom_range(0, 99);
            if (pick < 35)      dst = known_station();
            else if (pick < 55) dst = pool_mac();
            else if (pick < 70) dst = random_mac();
            else if (pick < 80) dst = src;
            else if (pick < 88) dst = MAC_ONES;
            else                dst = MAC_W'(1) << $urandom_range(0, MAC_W - 1);
            send_frame(port, src, dst, 1'b0, none);
         end
         steady_stretch = 1'b0;
      end

      // wait for the last decisions, then watch for strays
      start <= 1'b0;
      while (decisions_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // compare each strobed decision with the oldest prediction
   always @(posedge clock) begin
      fwd_decision_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (decisions_due.size() == 0) begin
            $error("unexpected decision: egress_mask %h flooded %b learn_dropped %b",
                   rsp_egress_mask, rsp_flooded, rsp_learn_dropped);
            error_count++;
         end else begin
            want = decisions_due.pop_front();
            if (rsp_egress_mask !== want.egress_mask) begin
               $error("egress_mask: expected %h, actual %h", want.egress_mask, rsp_egress_mask);
               error_count++;
            end
            if (rsp_flooded !== want.flooded) begin
               $error("flooded: expected %b, actual %b", want.flooded, rsp_flooded);
               error_count++;
            end
            if (rsp_learn_dropped !== want.learn_dropped) begin
               $error("learn_dropped: expected %b, actual %b",
                      want.learn_dropped, rsp_learn_dropped);
               error_count++;
            end
         end
      end
   end

   // run limit
   initial begin
      #RUN_LIMIT_NS;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
